### design/fpr_pkg.sv
package fpr_pkg;

    localparam int WORD_CHARS_DEF  = 15;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int COUNT_W         = 4;
    localparam int WORD_W          = 32;
    localparam int FIELDS_W        = 19;
    localparam int MOTOR_W         = 18;
    localparam int REQ_W           = 6;

    localparam logic [7:0] CHAR_OPEN  = 8'h53;
    localparam logic [7:0] CHAR_CLOSE = 8'h45;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       chunk_end;
    } byte_item_t;

    typedef struct packed {
        logic [7:0] pwm_one;
        logic [7:0] pwm_two;
        logic       dir_one;
        logic       dir_two;
        logic       light_enable;
        logic [4:0] requests;
        logic       shutdown_req;
        logic       motor_changed;
        logic       light_changed;
    } cmd_item_t;

    typedef enum logic [1:0] {
        TOK_OPEN,
        TOK_CLOSE,
        TOK_TEXT
    } tok_kind_t;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_PLUS,
        CLS_MINUS,
        CLS_DIGIT,
        CLS_OTHER
    } char_cls_t;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        tok_kind_t  kind;
        char_cls_t  cls;
        logic [3:0] digit;
        logic       chunk_end;
    } tok_t;

endpackage

### design/fpr_front.sv
module fpr_front
(
    input  fpr_pkg::byte_item_t byte_item,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  logic                queue_full,
    output logic                push,
    output fpr_pkg::tok_t       tok
);
    import fpr_pkg::*;

    logic [7:0] c;

    assign c          = byte_item.rx_byte;
    assign byte_stall = queue_full;
    assign push       = byte_valid && !queue_full;

    always_comb
    begin
        tok.chunk_end = byte_item.chunk_end;
        tok.digit     = 4'(c - CHAR_ZERO);

        if (c == CHAR_OPEN)
        begin
            tok.kind = TOK_OPEN;
        end
        else if (c == CHAR_CLOSE)
        begin
            tok.kind = TOK_CLOSE;
        end
        else
        begin
            tok.kind = TOK_TEXT;
        end

        if (c == CHAR_SPACE || c inside {[CHAR_TAB:CHAR_CR]})
        begin
            tok.cls = CLS_SPACE;
        end
        else if (c == CHAR_PLUS)
        begin
            tok.cls = CLS_PLUS;
        end
        else if (c == CHAR_MINUS)
        begin
            tok.cls = CLS_MINUS;
        end
        else if (c inside {[CHAR_ZERO:CHAR_NINE]})
        begin
            tok.cls = CLS_DIGIT;
        end
        else
        begin
            tok.cls = CLS_OTHER;
        end
    end

endmodule

### design/fpr_queue.sv
module fpr_queue
#(
    parameter int DEPTH = fpr_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fpr_pkg::tok_t push_data,
    output logic          full,
    input  logic          pop,
    output fpr_pkg::tok_t pop_data,
    output logic          not_empty
);
    import fpr_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tok_t             slot_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/fpr_back.sv
module fpr_back
#(
    parameter int WORD_CHARS = fpr_pkg::WORD_CHARS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tok_valid,
    input  fpr_pkg::tok_t      tok,
    output logic               tok_pop,
    output logic               cmd_valid,
    input  logic               cmd_stall,
    output fpr_pkg::cmd_item_t cmd_item
);
    import fpr_pkg::*;

    logic                in_frame_reg,  in_frame_next;
    logic [COUNT_W-1:0]  count_reg,     count_next;
    phase_t              phase_reg,     phase_next;
    logic                neg_reg,       neg_next;
    logic [WORD_W-1:0]   value_reg,     value_next;
    logic                has_word_reg,  has_word_next;
    logic [REQ_W-1:0]    req_reg,       req_next;
    logic [FIELDS_W-1:0] fields_reg,    fields_next;
    logic [MOTOR_W-1:0]  motor_reg,     motor_next;
    logic                light_reg,     light_next;
    logic                cmd_valid_reg, cmd_valid_next;
    cmd_item_t           cmd_item_reg,  cmd_item_next;

    logic [WORD_W-1:0]   word;
    logic [WORD_W-1:0]   value_acc;
    logic                emit;

    assign tok_pop   = tok_valid && (!cmd_valid_reg || !cmd_stall);
    assign cmd_valid = cmd_valid_reg;
    assign cmd_item  = cmd_item_reg;

    assign word      = neg_reg ? (WORD_W'(0) - value_reg) : value_reg;
    assign value_acc = (value_reg << 3) + (value_reg << 1) + WORD_W'(tok.digit);

    always_comb
    begin
        in_frame_next  = in_frame_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        value_next     = value_reg;
        has_word_next  = has_word_reg;
        req_next       = req_reg;
        fields_next    = fields_reg;
        motor_next     = motor_reg;
        light_next     = light_reg;
        cmd_item_next  = cmd_item_reg;
        emit           = 1'b0;
        cmd_valid_next = cmd_valid_reg && cmd_stall;

        if (tok_pop)
        begin
            case (tok.kind)
                TOK_OPEN:
                begin
                    in_frame_next = 1'b1;
                    count_next    = '0;
                    phase_next    = PH_SPACE;
                    neg_next      = 1'b0;
                    value_next    = '0;
                end
                TOK_CLOSE:
                begin
                    if (in_frame_reg)
                    begin
                        if (count_reg != '0)
                        begin
                            req_next      = req_reg | {word[23], word[22], word[24],
                                                       word[21], word[20], word[19]};
                            fields_next   = word[FIELDS_W-1:0];
                            has_word_next = 1'b1;
                        end
                        in_frame_next = 1'b0;
                    end
                end
                TOK_TEXT:
                begin
                    if (in_frame_reg && count_reg < COUNT_W'(WORD_CHARS))
                    begin
                        count_next = count_reg + 1'b1;
                        case (phase_reg)
                            PH_SPACE:
                            begin
                                case (tok.cls)
                                    CLS_SPACE:
                                    begin
                                        phase_next = PH_SPACE;
                                    end
                                    CLS_PLUS, CLS_MINUS:
                                    begin
                                        neg_next   = (tok.cls == CLS_MINUS);
                                        phase_next = PH_DIGITS;
                                    end
                                    CLS_DIGIT:
                                    begin
                                        value_next = value_acc;
                                        phase_next = PH_DIGITS;
                                    end
                                    default:
                                    begin
                                        phase_next = PH_DONE;
                                    end
                                endcase
                            end
                            PH_DIGITS:
                            begin
                                if (tok.cls == CLS_DIGIT)
                                begin
                                    value_next = value_acc;
                                end
                                else
                                begin
                                    phase_next = PH_DONE;
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
                default:
                begin
                    in_frame_next = in_frame_reg;
                end
            endcase

            emit = tok.chunk_end && has_word_next;
        end

        if (emit)
        begin
            cmd_item_next.pwm_one       = fields_next[7:0];
            cmd_item_next.pwm_two       = fields_next[15:8];
            cmd_item_next.dir_one       = fields_next[16];
            cmd_item_next.dir_two       = fields_next[17];
            cmd_item_next.light_enable  = fields_next[18];
            cmd_item_next.requests      = req_next[4:0];
            cmd_item_next.shutdown_req  = req_next[5];
            cmd_item_next.motor_changed = (fields_next[MOTOR_W-1:0] != motor_reg);
            cmd_item_next.light_changed = (fields_next[18] != light_reg);
            motor_next                  = fields_next[MOTOR_W-1:0];
            light_next                  = fields_next[18];
            has_word_next               = 1'b0;
            req_next                    = '0;
            cmd_valid_next              = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            count_reg     <= '0;
            phase_reg     <= PH_SPACE;
            neg_reg       <= 1'b0;
            value_reg     <= '0;
            has_word_reg  <= 1'b0;
            req_reg       <= '0;
            fields_reg    <= '0;
            motor_reg     <= '0;
            light_reg     <= 1'b0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg  <= in_frame_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            value_reg     <= value_next;
            has_word_reg  <= has_word_next;
            req_reg       <= req_next;
            fields_reg    <= fields_next;
            motor_reg     <= motor_next;
            light_reg     <= light_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_item_reg <= cmd_item_next;
    end

endmodule

### design/framed_decimal_command_parser.sv
// Channel   Ports                                     Moves
// bytes     byte_valid, byte_stall, byte_item        one received character per transfer
// commands  cmd_valid, cmd_stall, cmd_item           one merged command per chunk
//
// One byte per cycle while the queue has room; the classifier feeds a QUEUE_DEPTH-entry
// queue; the decoder drains one entry per unstalled cycle into one output register.
// A command appears once the chunk's last byte clears the queue and the output register.
// Reset (rst_n low) empties the queue and clears all frame, merge and history state.
// A stalled command holds the decoder; bytes keep landing until the queue is full.
module framed_decimal_command_parser
#(
    parameter int WORD_CHARS  = fpr_pkg::WORD_CHARS_DEF,
    parameter int QUEUE_DEPTH = fpr_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  fpr_pkg::byte_item_t byte_item,
    output logic                cmd_valid,
    input  logic                cmd_stall,
    output fpr_pkg::cmd_item_t  cmd_item
);
    import fpr_pkg::*;

    logic queue_full;
    logic push;
    tok_t push_tok;
    logic pop;
    tok_t pop_tok;
    logic tok_valid;

    fpr_front u_front
    (
        .byte_item  (byte_item),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .queue_full (queue_full),
        .push       (push),
        .tok        (push_tok)
    );

    fpr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_tok),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_tok),
        .not_empty (tok_valid)
    );

    fpr_back #(.WORD_CHARS(WORD_CHARS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (pop_tok),
        .tok_pop   (pop),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item)
    );

endmodule

### design/fpr_checker.sv
module fpr_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_stall,
    input fpr_pkg::cmd_item_t cmd_item
);
    import fpr_pkg::*;

    logic [MOTOR_W-1:0] motor;

    assign motor = {cmd_item.dir_two, cmd_item.dir_one, cmd_item.pwm_two, cmd_item.pwm_one};

    // a stalled command holds
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd_item))
        else $error("command changed while stalled");

    // nothing offered straight out of reset
    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !cmd_valid)
        else $error("command offered at reset release");

    // back-to-back commands: change flags compare with the one just transferred
    a_motor_flag: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall ##1 cmd_valid |->
            cmd_item.motor_changed == (motor != $past(motor)))
        else $error("motor change flag wrong");

    a_light_flag: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall ##1 cmd_valid |->
            cmd_item.light_changed == (cmd_item.light_enable != $past(cmd_item.light_enable)))
        else $error("light change flag wrong");

endmodule

bind framed_decimal_command_parser fpr_checker u_fpr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item)
);
